@@ hdl/pid_controller_periodic_integral_reset_assert.svh @@
// Assertion macros for the PID controller block.
// Uses the clk and rst_n names of the module that expands them.
`ifndef PID_CONTROLLER_PERIODIC_INTEGRAL_RESET_ASSERT_SVH
`define PID_CONTROLLER_PERIODIC_INTEGRAL_RESET_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define PCPIR_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define PCPIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PCPIR_ASSERT_IMPLIES(label, ante, cons, msg)

`define PCPIR_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ hdl/pcpir_pkg.sv @@
// Shared types and constants for the PID controller block.
// No dependencies.
`timescale 1ns / 1ps

package pcpir_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int FRAC_BITS  = 8;
    localparam int OUT_W      = 16;
    localparam int PERIOD_W   = 16;
    localparam int INTEG_W    = 32;
    localparam int ERR_W      = SAMPLE_W + 1;
    localparam int DERIV_W    = SAMPLE_W + 2;
    localparam int PROD_P_W   = GAIN_W + ERR_W;
    localparam int PROD_I_W   = GAIN_W + INTEG_W;
    localparam int PROD_D_W   = GAIN_W + DERIV_W;
    localparam int ACC_W      = PROD_I_W + 2;
    localparam int SHIFT_W    = ACC_W - FRAC_BITS;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    // Register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_OUT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_OUT       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WINDUP_PERIOD = 3'd5;

    localparam logic ACTION_STEP  = 1'b0;
    localparam logic ACTION_CLEAR = 1'b1;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic signed [OUT_W-1:0]  min_out;
        logic signed [OUT_W-1:0]  max_out;
        logic [PERIOD_W-1:0]      windup_period;
    } cfg_t;

    // Word handed from the front to the back: the three PID terms
    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DERIV_W-1:0] deriv;
    } step_word_t;

endpackage

@@ hdl/pcpir_front.sv @@
// Front end: accepts input words, runs the error / integral / derivative
// state update and hands the terms to the step queue. Depends on pcpir_pkg.
`timescale 1ns / 1ps

module pcpir_front
    import pcpir_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  logic                       push,
    output logic                       full,
    input  logic                       action,
    input  logic signed [SAMPLE_W-1:0] feedback,
    input  logic signed [SAMPLE_W-1:0] setpoint,
    input  logic                       q_full,
    output logic                       q_push,
    output step_word_t                 q_word
);

    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic signed [ERR_W-1:0]   prev_err_reg, prev_err_next;
    logic [PERIOD_W-1:0]       count_reg, count_next;

    logic                      accept;
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W:0]   sum_wide;
    logic signed [INTEG_W-1:0] sum_sat;
    logic [PERIOD_W:0]         count_inc;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        err       = ERR_W'(setpoint) - ERR_W'(feedback);
        sum_wide  = (INTEG_W+1)'(integ_reg) + (INTEG_W+1)'(err);
        // top two bits differ: the 32-bit sum overflowed
        if (sum_wide[INTEG_W] != sum_wide[INTEG_W-1])
        begin
            sum_sat = sum_wide[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        end
        else
        begin
            sum_sat = sum_wide[INTEG_W-1:0];
        end
        count_inc = {1'b0, count_reg} + (PERIOD_W+1)'(1);
    end

    always_comb
    begin
        q_word.err   = err;
        q_word.integ = sum_sat;
        q_word.deriv = DERIV_W'(err) - DERIV_W'(prev_err_reg);
        q_push       = accept && (action == ACTION_STEP);
    end

    always_comb
    begin
        integ_next    = integ_reg;
        prev_err_next = prev_err_reg;
        count_next    = count_reg;
        if (accept)
        begin
            if (action == ACTION_CLEAR)
            begin
                integ_next    = '0;
                prev_err_next = '0;
            end
            else
            begin
                prev_err_next = err;
                // forced clear once the period is reached
                if (count_inc >= {1'b0, cfg.windup_period})
                begin
                    integ_next = '0;
                    count_next = '0;
                end
                else
                begin
                    integ_next = sum_sat;
                    count_next = count_inc[PERIOD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg    <= '0;
            prev_err_reg <= '0;
            count_reg    <= '0;
        end
        else
        begin
            integ_reg    <= integ_next;
            prev_err_reg <= prev_err_next;
            count_reg    <= count_next;
        end
    end

endmodule

@@ hdl/pcpir_step_queue.sv @@
// Short queue of step words between the front and the back.
// Depends on pcpir_pkg.
`timescale 1ns / 1ps

module pcpir_step_queue
    import pcpir_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr,
    input  step_word_t wr_word,
    output logic       full,
    output logic       valid,
    input  logic       rd,
    output step_word_t rd_word
);

    step_word_t             slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_wr, do_rd;

    assign full    = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign rd_word = slot_reg[rd_ptr_reg];
    assign do_wr   = wr && !full;
    assign do_rd   = rd && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(do_wr);
        rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(do_rd);
        count_next  = count_reg + QUEUE_CNT_W'(do_wr) - QUEUE_CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_word;
        end
    end

endmodule

@@ hdl/pcpir_back.sv @@
// Back end: gain multiplies, accumulate, shift and clamp, then the result
// queue toward the output ports. Depends on pcpir_pkg.
`timescale 1ns / 1ps

module pcpir_back
    import pcpir_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    q_valid,
    input  step_word_t              q_word,
    output logic                    q_pop,
    output logic                    empty,
    input  logic                    pop,
    output logic signed [OUT_W-1:0] drive,
    output logic                    clamped
);

    // stage 1: products
    logic                       v1_reg, v1_next;
    logic signed [PROD_P_W-1:0] pp_reg;
    logic signed [PROD_I_W-1:0] pi_reg;
    logic signed [PROD_D_W-1:0] pd_reg;
    // stage 2: accumulated sum
    logic                       v2_reg, v2_next;
    logic signed [ACC_W-1:0]    acc_reg;

    // result queue
    logic signed [OUT_W-1:0] res_drive_reg [QUEUE_DEPTH];
    logic                    res_clamp_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]  count_reg, count_next;
    logic [QUEUE_CNT_W:0]    committed;
    logic                    do_rd;

    logic signed [SHIFT_W-1:0] shifted;
    logic signed [SHIFT_W-1:0] min_ext, max_ext;
    logic                      lo_hit, hi_hit;
    logic signed [OUT_W-1:0]   res_drive;
    logic                      res_clamp;

    // only take a word when the result queue has room for everything in flight
    always_comb
    begin
        committed = (QUEUE_CNT_W+1)'(count_reg) + (QUEUE_CNT_W+1)'(v1_reg)
                  + (QUEUE_CNT_W+1)'(v2_reg);
        q_pop     = q_valid && (committed < (QUEUE_CNT_W+1)'(QUEUE_DEPTH));
        v1_next   = q_pop;
        v2_next   = v1_reg;
    end

    always_comb
    begin
        shifted = SHIFT_W'(acc_reg >>> FRAC_BITS);
        min_ext = SHIFT_W'(cfg.min_out);
        max_ext = SHIFT_W'(cfg.max_out);
        lo_hit  = shifted < min_ext;
        // upper limit is applied after the lower one
        hi_hit  = lo_hit ? (cfg.min_out > cfg.max_out) : (shifted > max_ext);
        if (hi_hit)
        begin
            res_drive = cfg.max_out;
        end
        else if (lo_hit)
        begin
            res_drive = cfg.min_out;
        end
        else
        begin
            res_drive = shifted[OUT_W-1:0];
        end
        res_clamp = lo_hit || hi_hit;
    end

    assign empty   = (count_reg == '0);
    assign do_rd   = pop && !empty;
    assign drive   = res_drive_reg[rd_ptr_reg];
    assign clamped = res_clamp_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(v2_reg);
        rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(do_rd);
        count_next  = count_reg + QUEUE_CNT_W'(v2_reg) - QUEUE_CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            v1_reg     <= v1_next;
            v2_reg     <= v2_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            pp_reg <= cfg.gain_p * q_word.err;
            pi_reg <= cfg.gain_i * q_word.integ;
            pd_reg <= cfg.gain_d * q_word.deriv;
        end
        if (v1_reg)
        begin
            acc_reg <= ACC_W'(pp_reg) + ACC_W'(pi_reg) + ACC_W'(pd_reg);
        end
        if (v2_reg)
        begin
            res_drive_reg[wr_ptr_reg] <= res_drive;
            res_clamp_reg[wr_ptr_reg] <= res_clamp;
        end
    end

endmodule

@@ hdl/pid_controller_periodic_integral_reset.sv @@
// PID step with saturating integral, periodic integral clear and output clamp.
// Path: step queue, product registers, accumulator, result queue, outputs.
// Throughput: one item per cycle while full is low, set by the integral update
// loop in the front end; gain products and clamp are pipelined in the back end.
// Reset: rst_n (async, active low) clears the integral, last error, step
// count and both queues, and loads the register defaults.
`timescale 1ns / 1ps
`include "pid_controller_periodic_integral_reset_assert.svh"

module pid_controller_periodic_integral_reset
    import pcpir_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         push,
    output logic                         full,
    input  logic                         action,
    input  logic signed [SAMPLE_W-1:0]   feedback,
    input  logic signed [SAMPLE_W-1:0]   setpoint,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [OUT_W-1:0]      drive,
    output logic                         clamped
);

    cfg_t       cfg_reg, cfg_next;
    logic       mid_push, mid_full, mid_valid, mid_pop;
    step_word_t mid_wr_word, mid_rd_word;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_GAIN_P:        cfg_next.gain_p        = cfg_data;
                REG_GAIN_I:        cfg_next.gain_i        = cfg_data;
                REG_GAIN_D:        cfg_next.gain_d        = cfg_data;
                REG_MIN_OUT:       cfg_next.min_out       = cfg_data;
                REG_MAX_OUT:       cfg_next.max_out       = cfg_data;
                REG_WINDUP_PERIOD: cfg_next.windup_period = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p        <= '0;
            cfg_reg.gain_i        <= '0;
            cfg_reg.gain_d        <= '0;
            cfg_reg.min_out       <= {1'b1, {(OUT_W-1){1'b0}}};
            cfg_reg.max_out       <= {1'b0, {(OUT_W-1){1'b1}}};
            cfg_reg.windup_period <= '1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pcpir_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (push),
        .full     (full),
        .action   (action),
        .feedback (feedback),
        .setpoint (setpoint),
        .q_full   (mid_full),
        .q_push   (mid_push),
        .q_word   (mid_wr_word)
    );

    pcpir_step_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (mid_push),
        .wr_word (mid_wr_word),
        .full    (mid_full),
        .valid   (mid_valid),
        .rd      (mid_pop),
        .rd_word (mid_rd_word)
    );

    pcpir_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (mid_valid),
        .q_word  (mid_rd_word),
        .q_pop   (mid_pop),
        .empty   (empty),
        .pop     (pop),
        .drive   (drive),
        .clamped (clamped)
    );

    `PCPIR_ASSERT_IMPLIES(a_clear_no_word, push && !full && action == ACTION_CLEAR, !mid_push, "clear item wrote a step word")
    `PCPIR_ASSERT_IMPLIES(a_step_word, push && !full && action == ACTION_STEP, mid_push, "accepted step wrote no step word")
    `PCPIR_ASSERT_IMPLIES(a_pop_valid, mid_pop, mid_valid, "back end took from an empty step queue")
    `PCPIR_ASSERT_NEXT(a_full_holds, full && !mid_pop, full, "step queue left full without a read")

endmodule
